// File: design/q10mr_pkg.sv
package q10mr_pkg;

    // field widths
    localparam int unsigned TEMP_W    = 15;
    localparam int unsigned NITRO_W   = 32;
    localparam int unsigned AREA_W    = 16;
    localparam int unsigned DAYL_W    = 17;
    localparam int unsigned FLUX_W    = 48;
    localparam int unsigned RATE_W    = 32;
    localparam int unsigned CN_W      = 16;
    localparam int unsigned FLAGS_W   = 2;

    // internal widths
    localparam int unsigned FACTOR_W  = 38;     // 2^((t-20)/10) in Q32
    localparam int unsigned BASE_W    = 38;     // n * 0.218 in Q32
    localparam int unsigned FLUX_USED_W = 43;   // tissue flux never reaches above this

    localparam int unsigned EXP2_TABLE_BITS_DEFAULT = 8;

    // arithmetic constants
    localparam logic [29:0] MRPERN_Q32   = 30'd936302871;   // 0.218 in Q32
    localparam logic [23:0] AREA_K_Q16   = 24'd13767133;    // 0.218 / (86400 * 12.011e-9)
    localparam logic [16:0] DAY_SECONDS  = 17'd86400;
    localparam logic [15:0] TEMP_BIAS    = 16'd35840;       // (16 * 10 - 20) deg C in Q8.8
    localparam logic [31:0] DIV10_RECIP  = 32'hCCCC_CCCD;   // floor(y / 10) = y * this >> 35
    localparam int unsigned DIV10_SHIFT  = 35;
    localparam logic [4:0]  EXP_POINT    = 5'd14;

    // day-length share: floor(x / 86400) = floor(floor(x / 128) / 675)
    // floor(y / 675) = y * ceil(2^63 / 675) >> 63, exact for y below 2^54
    localparam int unsigned DAY_PRESHIFT    = 7;
    localparam int unsigned DAY_X_W         = 54;
    localparam int unsigned DAY_HALF_W      = 27;
    localparam logic [53:0] DAY_RECIP       = 54'd13664254869414483;
    localparam int unsigned DAY_RECIP_SHIFT = 63;

    // per-area divider
    localparam int unsigned AREA_NUM_W   = 62;
    localparam int unsigned AREA_DEN_W   = 48;
    localparam int unsigned AREA_STAGES  = 16;
    localparam int unsigned AREA_STEPS   = 2;

    // pipeline latencies in cycles
    localparam int unsigned LAT_FACTOR   = 4;
    localparam int unsigned LAT_TISSUE   = 3;
    localparam int unsigned LAT_SHARE    = 5;
    localparam int unsigned LAT_AREA     = 2 + AREA_STAGES;
    localparam int unsigned LAT_CORE     = LAT_FACTOR + LAT_AREA;

    typedef enum logic [0:0] {
        CFG_CARBON_TO_NITROGEN = 1'b0,
        CFG_WOODY_ENABLE       = 1'b1
    } cfg_reg_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] bitv;
        x = x_in;
        r = 64'd0;
        bitv = 64'd1 << 62;
        for (int s = 0; s < 32; s++)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
            begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // entry idx of the table 2^(idx / 2^bits) in Q30, evaluated at elaboration
    function automatic logic [31:0] pow2_entry(input int unsigned idx,
                                               input int unsigned bits);
        logic [63:0] roots [17];
        logic [63:0] acc;
        roots[0] = 64'd1 << 31;
        for (int b = 1; b <= 16; b++)
        begin
            if (b <= bits)
                roots[b] = isqrt64(roots[b - 1] << 30);
            else
                roots[b] = 64'd0;
        end
        acc = 64'd1 << 30;
        for (int b = 0; b <= 16; b++)
        begin
            if (b <= bits && ((idx >> b) & 1) != 0)
                acc = (acc * roots[bits - b]) >> 30;
        end
        return acc[31:0];
    endfunction

endpackage

// File: design/q10mr_factor.sv
module q10mr_factor #(
    parameter int unsigned TABLE_BITS = q10mr_pkg::EXP2_TABLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [q10mr_pkg::TEMP_W-1:0] temp,
    output logic [q10mr_pkg::FACTOR_W-1:0]      factor
);
    import q10mr_pkg::*;

    localparam int unsigned TAB_N  = 1 << TABLE_BITS;
    localparam int unsigned SH     = 16 - TABLE_BITS;
    localparam int unsigned IDX_W  = TABLE_BITS + 1;
    localparam int unsigned PROD_W = 32 + SH;

    logic [31:0] pow2_tab [TAB_N + 1];

    for (genvar g = 0; g <= TAB_N; g++)
    begin : g_tab
        localparam logic [31:0] ENTRY = pow2_entry(g, TABLE_BITS);
        assign pow2_tab[g] = ENTRY;
    end

    // stage 1: exponent (t - 20) / 10 + 16 in Q16
    logic [16:0] biased;
    logic [23:0] scaled;
    logic [55:0] recip_prod;
    logic [20:0] expo_reg;

    assign biased     = 17'(temp) + 17'(TEMP_BIAS);
    assign scaled     = {biased[15:0], 8'd0};
    assign recip_prod = 56'(scaled) * 56'(DIV10_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
            expo_reg <= recip_prod[DIV10_SHIFT + 20:DIV10_SHIFT];
    end

    // stage 2: table lookup of the two neighbors
    logic [TABLE_BITS-1:0] idx;
    logic [IDX_W-1:0]      idx_lo;
    logic [IDX_W-1:0]      idx_hi;
    logic [31:0]           tab_lo;
    logic [31:0]           tab_hi;
    logic [31:0]           lo_reg;
    logic [31:0]           step_reg;
    logic [SH-1:0]         frac_reg;
    logic [4:0]            whole_s2_reg;

    assign idx    = expo_reg[15:SH];
    assign idx_lo = {1'b0, idx};
    assign idx_hi = idx_lo + IDX_W'(1);
    assign tab_lo = pow2_tab[idx_lo];
    assign tab_hi = pow2_tab[idx_hi];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg       <= tab_lo;
            step_reg     <= tab_hi - tab_lo;
            frac_reg     <= expo_reg[SH-1:0];
            whole_s2_reg <= expo_reg[20:16];
        end
    end

    // stage 3: linear interpolation
    logic [PROD_W-1:0] interp_prod;
    logic [31:0]       mant_reg;
    logic [4:0]        whole_s3_reg;

    assign interp_prod = PROD_W'(step_reg) * PROD_W'(frac_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mant_reg     <= lo_reg + interp_prod[PROD_W-1:SH];
            whole_s3_reg <= whole_s2_reg;
        end
    end

    // stage 4: scale by the integer part of the exponent
    logic [FACTOR_W-1:0] mant_ext;
    logic [FACTOR_W-1:0] factor_next;
    logic [FACTOR_W-1:0] factor_reg;

    assign mant_ext = FACTOR_W'(mant_reg);

    always_comb
    begin
        if (whole_s3_reg >= EXP_POINT)
            factor_next = mant_ext << (whole_s3_reg - EXP_POINT);
        else
            factor_next = mant_ext >> (EXP_POINT - whole_s3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            factor_reg <= factor_next;
    end

    assign factor = factor_reg;

endmodule

// File: design/q10mr_tissue.sv
module q10mr_tissue (
    input  logic                              clk,
    input  logic                              en,
    input  logic [q10mr_pkg::NITRO_W-1:0]     nitrogen,
    input  logic [q10mr_pkg::FACTOR_W-1:0]    factor,
    output logic [q10mr_pkg::FLUX_W-1:0]      flux
);
    import q10mr_pkg::*;

    // stage 1: n * 0.218
    logic [61:0]          base_prod;
    logic [BASE_W-1:0]    base_reg;
    logic [FACTOR_W-1:0]  fac_reg;

    assign base_prod = 62'(nitrogen) * 62'(MRPERN_Q32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_prod[61:24];
            fac_reg  <= factor;
        end
    end

    // stage 2: partial products of base * factor
    logic [63:0] pp_ll_reg;
    logic [37:0] pp_lh_reg;
    logic [37:0] pp_hl_reg;
    logic [11:0] pp_hh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= 64'(base_reg[31:0]) * 64'(fac_reg[31:0]);
            pp_lh_reg <= 38'(base_reg[31:0]) * 38'(fac_reg[FACTOR_W-1:32]);
            pp_hl_reg <= 38'(base_reg[BASE_W-1:32]) * 38'(fac_reg[31:0]);
            pp_hh_reg <= 12'(base_reg[BASE_W-1:32]) * 12'(fac_reg[FACTOR_W-1:32]);
        end
    end

    // stage 3: sum, dropping the low 32 bits (fits well under 48 bits)
    logic [FLUX_W-1:0] flux_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            flux_reg <= FLUX_W'(pp_ll_reg[63:32]) + FLUX_W'(pp_lh_reg)
                      + FLUX_W'(pp_hl_reg) + {4'd0, pp_hh_reg, 32'd0};
    end

    assign flux = flux_reg;

endmodule

// File: design/q10mr_dayshare.sv
module q10mr_dayshare (
    input  logic                          clk,
    input  logic                          en,
    input  logic [q10mr_pkg::FLUX_W-1:0]  flux,
    input  logic [q10mr_pkg::DAYL_W-1:0]  share,
    output logic [q10mr_pkg::FLUX_W-1:0]  part
);
    import q10mr_pkg::*;

    localparam int unsigned PP_W  = 2 * DAY_HALF_W;
    localparam int unsigned TOT_W = DAY_RECIP_SHIFT + FLUX_W;

    // stage 1: flux * seconds as two partial products
    logic [48:0] pp_l_reg;
    logic [32:0] pp_h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_l_reg <= 49'(flux[31:0]) * 49'(share);
            pp_h_reg <= 33'(flux[FLUX_W-1:32]) * 33'(share);
        end
    end

    // stage 2: sum and take off the power-of-two part of 86400
    logic [64:0]          prod_sum;
    logic [DAY_X_W-1:0]   x_reg;

    assign prod_sum = 65'(pp_l_reg) + {pp_h_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
            x_reg <= prod_sum[DAY_PRESHIFT + DAY_X_W - 1:DAY_PRESHIFT];
    end

    // stage 3: x times the reciprocal of 675, four partial products
    logic [PP_W-1:0] rp_ll_reg;
    logic [PP_W-1:0] rp_lh_reg;
    logic [PP_W-1:0] rp_hl_reg;
    logic [PP_W-1:0] rp_hh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_ll_reg <= PP_W'(x_reg[DAY_HALF_W-1:0])
                       * PP_W'(DAY_RECIP[DAY_HALF_W-1:0]);
            rp_lh_reg <= PP_W'(x_reg[DAY_HALF_W-1:0])
                       * PP_W'(DAY_RECIP[DAY_X_W-1:DAY_HALF_W]);
            rp_hl_reg <= PP_W'(x_reg[DAY_X_W-1:DAY_HALF_W])
                       * PP_W'(DAY_RECIP[DAY_HALF_W-1:0]);
            rp_hh_reg <= PP_W'(x_reg[DAY_X_W-1:DAY_HALF_W])
                       * PP_W'(DAY_RECIP[DAY_X_W-1:DAY_HALF_W]);
        end
    end

    // stage 4: cross terms
    logic [PP_W:0]   rp_mid_reg;
    logic [PP_W-1:0] rp_ll2_reg;
    logic [PP_W-1:0] rp_hh2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_mid_reg <= (PP_W + 1)'(rp_lh_reg) + (PP_W + 1)'(rp_hl_reg);
            rp_ll2_reg <= rp_ll_reg;
            rp_hh2_reg <= rp_hh_reg;
        end
    end

    // stage 5: full product, keep the quotient bits
    logic [TOT_W-1:0]  rp_total;
    logic [FLUX_W-1:0] part_reg;

    assign rp_total = TOT_W'(rp_ll2_reg) + (TOT_W'(rp_mid_reg) << DAY_HALF_W)
                    + (TOT_W'(rp_hh2_reg) << PP_W);

    always_ff @(posedge clk)
    begin
        if (en)
            part_reg <= rp_total[TOT_W-1:DAY_RECIP_SHIFT];
    end

    assign part = part_reg;

endmodule

// File: design/q10mr_area.sv
module q10mr_area (
    input  logic                            clk,
    input  logic                            en,
    input  logic [q10mr_pkg::AREA_W-1:0]    area,
    input  logic [q10mr_pkg::CN_W-1:0]      cn,
    input  logic [q10mr_pkg::FACTOR_W-1:0]  factor,
    output logic [q10mr_pkg::RATE_W-1:0]    rate
);
    import q10mr_pkg::*;

    // stage 1: divisor and numerator partial products
    logic [31:0] prod_p_reg;
    logic [55:0] num_l_reg;
    logic [29:0] num_h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_p_reg <= 32'(area) * 32'(cn);
            num_l_reg  <= 56'(AREA_K_Q16) * 56'(factor[31:0]);
            num_h_reg  <= 30'(AREA_K_Q16) * 30'(factor[FACTOR_W-1:32]);
        end
    end

    // stage 2: full numerator, overflow check, divider setup
    logic [AREA_NUM_W-1:0] num;
    logic [AREA_DEN_W-1:0] den;
    logic                  sat;

    assign num = AREA_NUM_W'(num_l_reg) + {num_h_reg, 32'd0};
    assign den = {prod_p_reg, 16'd0};
    assign sat = AREA_DEN_W'(num[AREA_NUM_W-1:32]) >= den;

    logic [AREA_DEN_W-1:0] rem_reg  [AREA_STAGES + 1];
    logic [RATE_W-1:0]     work_reg [AREA_STAGES + 1];
    logic [AREA_DEN_W-1:0] den_reg  [AREA_STAGES + 1];
    logic                  sat_reg  [AREA_STAGES + 1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= sat ? '0 : AREA_DEN_W'(num[AREA_NUM_W-1:32]);
            work_reg[0] <= num[31:0];
            den_reg[0]  <= den;
            sat_reg[0]  <= sat;
        end
    end

    // restoring division, two quotient bits per stage
    for (genvar s = 1; s <= AREA_STAGES; s++)
    begin : g_div
        logic [RATE_W-1:0]     work_next;
        logic [AREA_DEN_W-1:0] rem_next;

        always_comb
        begin
            logic [AREA_DEN_W:0] trial;
            work_next = work_reg[s - 1];
            rem_next  = rem_reg[s - 1];
            for (int k = 0; k < AREA_STEPS; k++)
            begin
                trial = {rem_next, work_next[RATE_W-1]};
                if (trial >= {1'b0, den_reg[s - 1]})
                begin
                    trial     = trial - {1'b0, den_reg[s - 1]};
                    work_next = {work_next[RATE_W-2:0], 1'b1};
                end
                else
                begin
                    work_next = {work_next[RATE_W-2:0], 1'b0};
                end
                rem_next = trial[AREA_DEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[s] <= work_next;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_reg[s - 1];
                sat_reg[s]  <= sat_reg[s - 1];
            end
        end
    end

    assign rate = sat_reg[AREA_STAGES] ? '1 : work_reg[AREA_STAGES];

endmodule

// File: design/q10_maintenance_respiration.sv
// Q10 maintenance respiration, one grid-cell day per transaction. The block takes one item
// per clock while item_ready is high and returns each result in order. The longest path is
// the per-area leaf rate path: the temperature factor (exponent, table lookup, interpolation,
// shift), then the area rate (products, setup and a 16-stage divider giving two quotient bits
// per stage), plus the result register. A two-deep output (result register and skid register)
// parks a result that is not taken while the pipeline moves on; item_ready falls while the
// skid register holds a result, and the whole pipeline then holds in place. Fluxes are Q16.32
// kgC/m2/d, rates Q16.16 umol/m2/s. Configuration takes effect for items accepted after the
// write, the carbon-to-nitrogen ratio also for items not yet in the area rate path; write it
// only while no transaction is in flight.
module q10_maintenance_respiration #(
    parameter int unsigned EXP2_TABLE_BITS = q10mr_pkg::EXP2_TABLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration
    input  logic                                cfg_write,
    input  q10mr_pkg::cfg_reg_t                 cfg_index,
    input  logic [q10mr_pkg::CN_W-1:0]          cfg_data,

    // input transaction
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [q10mr_pkg::FLAGS_W-1:0]       presence_flags,
    input  logic [q10mr_pkg::NITRO_W-1:0]       leaf_nitrogen,
    input  logic [q10mr_pkg::NITRO_W-1:0]       root_nitrogen,
    input  logic [q10mr_pkg::NITRO_W-1:0]       stem_nitrogen,
    input  logic [q10mr_pkg::NITRO_W-1:0]       coarse_nitrogen,
    input  logic signed [q10mr_pkg::TEMP_W-1:0] temp_daylight,
    input  logic signed [q10mr_pkg::TEMP_W-1:0] temp_darkness,
    input  logic signed [q10mr_pkg::TEMP_W-1:0] temp_mean,
    input  logic signed [q10mr_pkg::TEMP_W-1:0] temp_ground,
    input  logic [q10mr_pkg::DAYL_W-1:0]        daylight_seconds,
    input  logic [q10mr_pkg::AREA_W-1:0]        sun_leaf_area,
    input  logic [q10mr_pkg::AREA_W-1:0]        shade_leaf_area,

    // result transaction
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [q10mr_pkg::FLUX_W-1:0]        leaf_daylight_flux,
    output logic [q10mr_pkg::FLUX_W-1:0]        leaf_darkness_flux,
    output logic [q10mr_pkg::FLUX_W-1:0]        root_flux,
    output logic [q10mr_pkg::FLUX_W-1:0]        stem_flux,
    output logic [q10mr_pkg::FLUX_W-1:0]        coarse_flux,
    output logic [q10mr_pkg::RATE_W-1:0]        sun_area_rate,
    output logic [q10mr_pkg::RATE_W-1:0]        shade_area_rate,
    output logic                                woody_valid
);
    import q10mr_pkg::*;

    typedef struct packed {
        logic [FLUX_W-1:0] leaf_day;
        logic [FLUX_W-1:0] leaf_night;
        logic [FLUX_W-1:0] root;
        logic [FLUX_W-1:0] stem;
        logic [FLUX_W-1:0] coarse;
        logic [RATE_W-1:0] sun;
        logic [RATE_W-1:0] shade;
        logic              woody;
    } result_t;

    // fields waiting for the temperature factors
    typedef struct packed {
        logic [NITRO_W-1:0] leaf_n;
        logic [NITRO_W-1:0] root_n;
        logic [NITRO_W-1:0] stem_n;
        logic [NITRO_W-1:0] coarse_n;
        logic [AREA_W-1:0]  sun_area;
        logic [AREA_W-1:0]  shade_area;
    } entry_t;

    typedef struct packed {
        logic [DAYL_W-1:0] day;
        logic [DAYL_W-1:0] night;
    } share_t;

    typedef struct packed {
        logic [FLUX_W-1:0] root;
        logic [FLUX_W-1:0] stem;
        logic [FLUX_W-1:0] coarse;
    } tissue_t;

    typedef struct packed {
        logic [FLUX_W-1:0] day;
        logic [FLUX_W-1:0] night;
    } leaf_t;

    typedef struct packed {
        logic leaves;
        logic roots;
        logic woody;
    } mask_t;

    localparam int unsigned ENTRY_D  = LAT_FACTOR;
    localparam int unsigned SHARE_D  = LAT_FACTOR + LAT_TISSUE;
    localparam int unsigned TISSUE_D = LAT_AREA - LAT_TISSUE;
    localparam int unsigned LEAF_D   = LAT_AREA - LAT_TISSUE - LAT_SHARE;

    // ---------------- configuration registers ----------------
    logic [CN_W-1:0] cn_reg;
    logic            woody_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cn_reg    <= CN_W'(6400);
            woody_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CARBON_TO_NITROGEN: cn_reg    <= cfg_data;
                CFG_WOODY_ENABLE:       woody_reg <= cfg_data[0];
            endcase
        end
    end

    // ---------------- flow control ----------------
    // whole pipeline moves together; it only stops while the skid register is full
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign adv        = !skid_valid_reg;
    assign item_ready = adv;

    // valid bit per stage, travels with the data
    logic [LAT_CORE-1:0] valid_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_pipe_reg <= '0;
        else if (adv)
            valid_pipe_reg <= {valid_pipe_reg[LAT_CORE-2:0], item_valid};
    end

    // ---------------- entry side delay lines ----------------
    logic [DAYL_W-1:0] dayl_clamped;
    entry_t            entry_pipe_reg  [ENTRY_D];
    share_t            share_pipe_reg  [SHARE_D];
    mask_t             mask_pipe_reg   [LAT_CORE];

    // day length beyond a full day counts as a full day
    assign dayl_clamped = (daylight_seconds > DAY_SECONDS) ? DAY_SECONDS : daylight_seconds;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_pipe_reg[0] <= '{leaf_n: leaf_nitrogen, root_n: root_nitrogen,
                                   stem_n: stem_nitrogen, coarse_n: coarse_nitrogen,
                                   sun_area: sun_leaf_area, shade_area: shade_leaf_area};
            for (int i = 1; i < ENTRY_D; i++)
                entry_pipe_reg[i] <= entry_pipe_reg[i - 1];

            share_pipe_reg[0] <= '{day: dayl_clamped, night: DAY_SECONDS - dayl_clamped};
            for (int i = 1; i < SHARE_D; i++)
                share_pipe_reg[i] <= share_pipe_reg[i - 1];

            mask_pipe_reg[0] <= '{leaves: presence_flags[0], roots: presence_flags[1],
                                  woody: woody_reg};
            for (int i = 1; i < LAT_CORE; i++)
                mask_pipe_reg[i] <= mask_pipe_reg[i - 1];
        end
    end

    // ---------------- temperature factors ----------------
    logic [FACTOR_W-1:0] fac_day;
    logic [FACTOR_W-1:0] fac_night;
    logic [FACTOR_W-1:0] fac_mean;
    logic [FACTOR_W-1:0] fac_soil;

    q10mr_factor #(.TABLE_BITS(EXP2_TABLE_BITS)) u_fac_day (
        .clk(clk), .en(adv), .temp(temp_daylight), .factor(fac_day));
    q10mr_factor #(.TABLE_BITS(EXP2_TABLE_BITS)) u_fac_night (
        .clk(clk), .en(adv), .temp(temp_darkness), .factor(fac_night));
    q10mr_factor #(.TABLE_BITS(EXP2_TABLE_BITS)) u_fac_mean (
        .clk(clk), .en(adv), .temp(temp_mean), .factor(fac_mean));
    q10mr_factor #(.TABLE_BITS(EXP2_TABLE_BITS)) u_fac_soil (
        .clk(clk), .en(adv), .temp(temp_ground), .factor(fac_soil));

    // ---------------- tissue fluxes ----------------
    entry_t            entry_at_fac;
    logic [FLUX_W-1:0] dflux;
    logic [FLUX_W-1:0] nflux;
    tissue_t           tissue_now;

    assign entry_at_fac = entry_pipe_reg[ENTRY_D - 1];

    q10mr_tissue u_tis_day (
        .clk(clk), .en(adv), .nitrogen(entry_at_fac.leaf_n), .factor(fac_day), .flux(dflux));
    q10mr_tissue u_tis_night (
        .clk(clk), .en(adv), .nitrogen(entry_at_fac.leaf_n), .factor(fac_night),
        .flux(nflux));
    q10mr_tissue u_tis_root (
        .clk(clk), .en(adv), .nitrogen(entry_at_fac.root_n), .factor(fac_soil),
        .flux(tissue_now.root));
    q10mr_tissue u_tis_stem (
        .clk(clk), .en(adv), .nitrogen(entry_at_fac.stem_n), .factor(fac_mean),
        .flux(tissue_now.stem));
    q10mr_tissue u_tis_coarse (
        .clk(clk), .en(adv), .nitrogen(entry_at_fac.coarse_n), .factor(fac_soil),
        .flux(tissue_now.coarse));

    // ---------------- day / night split of leaf respiration ----------------
    leaf_t leaf_now;

    q10mr_dayshare u_share_day (
        .clk(clk), .en(adv), .flux(dflux), .share(share_pipe_reg[SHARE_D - 1].day),
        .part(leaf_now.day));
    q10mr_dayshare u_share_night (
        .clk(clk), .en(adv), .flux(nflux), .share(share_pipe_reg[SHARE_D - 1].night),
        .part(leaf_now.night));

    // ---------------- per-area leaf rates ----------------
    logic [RATE_W-1:0] sun_rate;
    logic [RATE_W-1:0] shade_rate;

    q10mr_area u_area_sun (
        .clk(clk), .en(adv), .area(entry_at_fac.sun_area), .cn(cn_reg), .factor(fac_day),
        .rate(sun_rate));
    q10mr_area u_area_shade (
        .clk(clk), .en(adv), .area(entry_at_fac.shade_area), .cn(cn_reg), .factor(fac_day),
        .rate(shade_rate));

    // ---------------- alignment of the shorter paths ----------------
    tissue_t tissue_pipe_reg [TISSUE_D];
    leaf_t   leaf_pipe_reg   [LEAF_D];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tissue_pipe_reg[0] <= tissue_now;
            for (int i = 1; i < TISSUE_D; i++)
                tissue_pipe_reg[i] <= tissue_pipe_reg[i - 1];
            leaf_pipe_reg[0] <= leaf_now;
            for (int i = 1; i < LEAF_D; i++)
                leaf_pipe_reg[i] <= leaf_pipe_reg[i - 1];
        end
    end

    // ---------------- masking and result registers ----------------
    mask_t   mask_last;
    tissue_t tissue_last;
    leaf_t   leaf_last;
    result_t result_next;
    result_t out_reg;
    result_t skid_reg;
    result_t shown;

    assign mask_last   = mask_pipe_reg[LAT_CORE - 1];
    assign tissue_last = tissue_pipe_reg[TISSUE_D - 1];
    assign leaf_last   = leaf_pipe_reg[LEAF_D - 1];

    // missing leaves or roots, or woody off, force the related fields to zero
    always_comb
    begin
        result_next.leaf_day   = mask_last.leaves ? leaf_last.day   : '0;
        result_next.leaf_night = mask_last.leaves ? leaf_last.night : '0;
        result_next.sun        = mask_last.leaves ? sun_rate        : '0;
        result_next.shade      = mask_last.leaves ? shade_rate      : '0;
        result_next.root       = mask_last.roots  ? tissue_last.root : '0;
        result_next.stem       = mask_last.woody  ? tissue_last.stem : '0;
        result_next.coarse     = mask_last.woody  ? tissue_last.coarse : '0;
        result_next.woody      = mask_last.woody;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_pipe_reg[LAT_CORE - 1];
            // result not taken while the pipe moves on: park it
            if (out_valid_reg && !result_ready)
                skid_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= result_next;
            if (out_valid_reg && !result_ready)
                skid_reg <= out_reg;
        end
    end

    // the parked result is older and goes first
    assign shown        = skid_valid_reg ? skid_reg : out_reg;
    assign result_valid = skid_valid_reg || out_valid_reg;

    assign leaf_daylight_flux = shown.leaf_day;
    assign leaf_darkness_flux = shown.leaf_night;
    assign root_flux          = shown.root;
    assign stem_flux          = shown.stem;
    assign coarse_flux        = shown.coarse;
    assign sun_area_rate      = shown.sun;
    assign shade_area_rate    = shown.shade;
    assign woody_valid        = shown.woody;

    // ---------------- assertions ----------------
    // skid only fills from an untaken result register
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result_ready))
        else $error("skid filled without a stalled result");

    // woody off means zero stem and coarse root fluxes
    a_woody_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !woody_valid) |-> (stem_flux == '0 && coarse_flux == '0))
        else $error("woody fluxes nonzero with woody_valid clear");

    // root and daylight leaf fluxes stay inside their worst-case range
    a_flux_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (root_flux[FLUX_W-1:FLUX_USED_W] == '0
                          && leaf_daylight_flux[FLUX_W-1:FLUX_USED_W] == '0))
        else $error("flux beyond its reachable range");

endmodule
